// ===== hw/rtl/disk_chain_reachability_defines.svh =====
// ----------------------------------------------------------------------------
// Disk chain reachability assertion macros
// Shared assertion forms used by the disk chain reachability RTL.
// ----------------------------------------------------------------------------
`ifndef DISK_CHAIN_REACHABILITY_DEFINES_SVH
`define DISK_CHAIN_REACHABILITY_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define DCR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define DCR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Disk chain reachability package
// Command codes and the item types of the command and response channels.
// ----------------------------------------------------------------------------
package dcr_pkg;

	localparam logic [2:0] CMD_WRITE_DISK = 3'd0;
	localparam logic [2:0] CMD_REBUILD    = 3'd1;
	localparam logic [2:0] CMD_SET_EDGE   = 3'd2;
	localparam logic [2:0] CMD_COUNT      = 3'd3;
	localparam logic [2:0] CMD_FIND_BEST  = 3'd4;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_BAD_INDEX = 1'b1;

	typedef struct packed {
		logic [2:0]         command;
		logic [5:0]         node_index;
		logic [5:0]         second_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        radius;
		logic               edge_value;
	} dcr_cmd_t;

	typedef struct packed {
		logic [6:0] reached_count;
		logic [5:0] best_node;
		logic       status;
	} dcr_rsp_t;

endpackage

// ===== hw/rtl/dcr_cover.sv =====
// ----------------------------------------------------------------------------
// Disk cover test pipeline
// Three-stage test of whether a streamed disk center lies inside a loaded disk.
// ----------------------------------------------------------------------------
module dcr_cover
	import dcr_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int IDX_W      = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [3*COORD_BITS-1:0] disk_src,
	input  logic                    probe_valid,
	input  logic [IDX_W-1:0]        probe_idx,
	input  logic [3*COORD_BITS-1:0] disk_dst,
	output logic                    hit_valid,
	output logic                    hit,
	output logic [IDX_W-1:0]        hit_idx,
	output logic                    busy
);

	localparam int DW   = COORD_BITS + 1;
	localparam int SQW  = 2 * DW;
	localparam int SUMW = SQW + 1;

	// Entry layout is {radius, y, x}.
	logic signed [COORD_BITS-1:0] xi_q, yi_q;
	logic [2*COORD_BITS-1:0]      rsq_q;

	logic signed [DW-1:0] dxs, dys;
	logic [DW-1:0]        dx_abs, dy_abs;

	logic             v_s1, v_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic [DW-1:0]    dx_s1, dy_s1;
	logic [SQW-1:0]   sx_s2, sy_s2;
	logic [SUMW-1:0]  sum;

	always_comb begin
		dxs    = $signed({disk_dst[COORD_BITS-1], disk_dst[COORD_BITS-1:0]})
			- $signed({xi_q[COORD_BITS-1], xi_q});
		dys    = $signed({disk_dst[2*COORD_BITS-1], disk_dst[2*COORD_BITS-1:COORD_BITS]})
			- $signed({yi_q[COORD_BITS-1], yi_q});
		dx_abs = dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
		dy_abs = dys[DW-1] ? DW'(-dys) : DW'(dys);
		sum    = {1'b0, sx_s2} + {1'b0, sy_s2};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			xi_q  <= disk_src[COORD_BITS-1:0];
			yi_q  <= disk_src[2*COORD_BITS-1:COORD_BITS];
			rsq_q <= disk_src[3*COORD_BITS-1:2*COORD_BITS]
				* disk_src[3*COORD_BITS-1:2*COORD_BITS];
		end
		idx_s1  <= probe_idx;
		dx_s1   <= dx_abs;
		dy_s1   <= dy_abs;
		idx_s2  <= idx_s1;
		sx_s2   <= dx_s1 * dx_s1;
		sy_s2   <= dy_s1 * dy_s1;
		hit_idx <= idx_s2;
		hit     <= (sum <= SUMW'(rsq_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			hit_valid <= 1'b0;
		end else begin
			v_s1      <= probe_valid;
			v_s2      <= v_s1;
			hit_valid <= v_s2;
		end
	end

	assign busy = v_s1 | v_s2 | hit_valid;

endmodule

// ===== hw/rtl/disk_chain_reachability.sv =====
// ----------------------------------------------------------------------------
// Disk chain reachability
// Disk table, adjacency matrix and chain reaction counter over the disks.
// ----------------------------------------------------------------------------
// Usage: a command item enters on cmd when cmd_valid is high and cmd_stall is
// low; each item gives exactly one response item on rsp, in order. The block
// works on one item at a time and holds cmd_stall high until that item's
// response is registered. Responses sit in an output register, so the next
// item is taken while an earlier response still waits on rsp_stall.
// The walk is bound by the single adjacency read port: one row read and
// one merge per reached disk. Rebuild streams one disk a cycle through the
// three-stage cover test and writes one row per source disk.
// Reset clears nodes_in_use, the response valid flag and every adjacency row
// valid bit, so the matrix reads as all zero at once; the disk table holds
// nothing defined until written. Write cfg_wdata only while no item is in flight.
// ----------------------------------------------------------------------------
`include "disk_chain_reachability_defines.svh"

module disk_chain_reachability
	import dcr_pkg::*;
#(
	parameter int MAX_NODES  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  dcr_cmd_t   cmd,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output dcr_rsp_t   rsp,
	input  logic       cfg_write_en,
	input  logic [6:0] cfg_wdata
);

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int DISK_W = 3 * COORD_BITS;

	typedef enum logic [8:0] {
		ST_IDLE       = 9'b000000001,
		ST_FINISH     = 9'b000000010,
		ST_SE_MOD     = 9'b000000100,
		ST_RB_START   = 9'b000001000,
		ST_RB_LATCH   = 9'b000010000,
		ST_RB_SCAN    = 9'b000100000,
		ST_RB_DRAIN   = 9'b001000000,
		ST_WALK_POP   = 9'b010000000,
		ST_WALK_MERGE = 9'b100000000
	} state_t;

	state_t state_q;

	logic [6:0]       nodes_q;
	logic [CNT_W-1:0] n_act;
	logic [MAX_NODES-1:0] active;

	// Disk table: one entry per disk, {radius, y, x}.
	logic [DISK_W-1:0] disk_mem [MAX_NODES];
	logic [DISK_W-1:0] disk_rdata_q;
	logic              disk_we;
	logic [IDX_W-1:0]  disk_raddr;

	// Adjacency rows with one valid bit per row; an invalid row reads as zero.
	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	logic [MAX_NODES-1:0] adj_rdata_q;
	logic [MAX_NODES-1:0] row_valid_q;
	logic                 adj_we;
	logic [IDX_W-1:0]     adj_waddr, adj_raddr;
	logic [MAX_NODES-1:0] adj_wdata;

	logic [MAX_NODES-1:0] visited_q, pending_q, row_q, se_row;
	logic [CNT_W-1:0]     cnt_q, best_cnt_q;
	logic [IDX_W-1:0]     best_idx_q, i_q, j_q, se_row_q, se_col_q, pop_idx;
	logic                 edge_q, best_mode_q, rv_s1, se_rv_s1;
	logic                 rd_v_s1;
	logic [IDX_W-1:0]     rd_j_s1;
	dcr_rsp_t             res_q;

	logic             accept, a_ok, b_ok, i_last, j_last, better, bad_idx;
	logic [IDX_W-1:0] a_idx, b_idx;
	logic [CNT_W-1:0] pick_cnt;
	logic [IDX_W-1:0] pick_idx;

	logic             hit_valid, hit, cover_busy, rb_empty;
	logic [IDX_W-1:0] hit_idx;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign a_idx     = IDX_W'(cmd.node_index);
	assign b_idx     = IDX_W'(cmd.second_index);
	assign a_ok      = 32'(cmd.node_index) < 32'(n_act);
	assign b_ok      = 32'(cmd.second_index) < 32'(n_act);
	assign i_last    = (CNT_W'(i_q) + CNT_W'(1)) == n_act;
	assign j_last    = (CNT_W'(j_q) + CNT_W'(1)) == n_act;
	assign rb_empty  = !rd_v_s1 && !cover_busy;

	// Values above the table size act as the table size.
	always_comb begin
		n_act = (32'(nodes_q) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(nodes_q);
		for (int k = 0; k < MAX_NODES; k++) begin
			active[k] = (32'(k) < 32'(n_act));
		end
	end

	// An index that is not below the active count is refused.
	always_comb begin
		case (cmd.command)
			CMD_WRITE_DISK, CMD_COUNT: begin
				bad_idx = !a_ok;
			end
			CMD_SET_EDGE: begin
				bad_idx = !(a_ok && b_ok);
			end
			CMD_FIND_BEST: begin
				bad_idx = (n_act == '0);
			end
			default: begin
				bad_idx = 1'b0;
			end
		endcase
	end

	// Lowest pending disk is visited next.
	always_comb begin
		pop_idx = '0;
		for (int k = MAX_NODES - 1; k >= 0; k--) begin
			if (pending_q[k]) begin
				pop_idx = IDX_W'(k);
			end
		end
	end

	// Find best keeps the lowest index among equal counts.
	always_comb begin
		better   = (i_q == '0) || (cnt_q > best_cnt_q);
		pick_cnt = better ? cnt_q : best_cnt_q;
		pick_idx = better ? i_q : best_idx_q;
	end

	always_comb begin
		se_row           = se_rv_s1 ? adj_rdata_q : '0;
		se_row[se_col_q] = edge_q;
		disk_we    = accept && (cmd.command == CMD_WRITE_DISK) && a_ok;
		disk_raddr = (state_q == ST_RB_SCAN) ? j_q : i_q;
		adj_raddr  = (state_q == ST_IDLE) ? a_idx : pop_idx;
		adj_we     = 1'b0;
		adj_waddr  = se_row_q;
		adj_wdata  = se_row;
		if (state_q == ST_SE_MOD) begin
			adj_we = 1'b1;
		end else if (state_q == ST_RB_DRAIN && rb_empty) begin
			adj_we    = 1'b1;
			adj_waddr = i_q;
			adj_wdata = row_q;
		end
	end

	always_ff @(posedge clk) begin
		if (disk_we) begin
			disk_mem[a_idx] <= {COORD_BITS'(cmd.radius), COORD_BITS'(cmd.pos_y),
				COORD_BITS'(cmd.pos_x)};
		end
		disk_rdata_q <= disk_mem[disk_raddr];
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_waddr] <= adj_wdata;
		end
		adj_rdata_q <= adj_mem[adj_raddr];
	end

	dcr_cover #(
		.COORD_BITS (COORD_BITS),
		.IDX_W      (IDX_W)
	) u_cover (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (state_q == ST_RB_LATCH),
		.disk_src    (disk_rdata_q),
		.probe_valid (rd_v_s1),
		.probe_idx   (rd_j_s1),
		.disk_dst    (disk_rdata_q),
		.hit_valid   (hit_valid),
		.hit         (hit),
		.hit_idx     (hit_idx),
		.busy        (cover_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nodes_q     <= '0;
			row_valid_q <= '0;
			visited_q   <= '0;
			pending_q   <= '0;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			rsp_valid   <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				nodes_q <= cfg_wdata;
			end
			if (state_q == ST_FINISH && (!rsp_valid || !rsp_stall)) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			if (adj_we) begin
				row_valid_q[adj_waddr] <= 1'b1;
			end
			rd_v_s1 <= (state_q == ST_RB_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q <= '{reached_count: '0, best_node: '0,
							status: bad_idx ? STATUS_BAD_INDEX : STATUS_OK};
						state_q <= ST_FINISH;
						case (cmd.command)
							CMD_WRITE_DISK: begin
							end
							CMD_REBUILD: begin
								row_valid_q <= '0;
								i_q         <= '0;
								if (n_act != '0) begin
									state_q <= ST_RB_START;
								end
							end
							CMD_SET_EDGE: begin
								if (a_ok && b_ok) begin
									se_row_q <= a_idx;
									se_col_q <= b_idx;
									edge_q   <= cmd.edge_value;
									se_rv_s1 <= row_valid_q[a_idx];
									state_q  <= ST_SE_MOD;
								end
							end
							CMD_COUNT: begin
								if (a_ok) begin
									best_mode_q <= 1'b0;
									pending_q   <= MAX_NODES'(1) << a_idx;
									visited_q   <= '0;
									cnt_q       <= '0;
									state_q     <= ST_WALK_POP;
								end
							end
							CMD_FIND_BEST: begin
								if (n_act != '0) begin
									best_mode_q <= 1'b1;
									i_q         <= '0;
									best_cnt_q  <= '0;
									best_idx_q  <= '0;
									pending_q   <= MAX_NODES'(1);
									visited_q   <= '0;
									cnt_q       <= '0;
									state_q     <= ST_WALK_POP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SE_MOD: begin
					state_q <= ST_FINISH;
				end
				ST_RB_START: begin
					state_q <= ST_RB_LATCH;
				end
				ST_RB_LATCH: begin
					j_q     <= '0;
					state_q <= ST_RB_SCAN;
				end
				ST_RB_SCAN: begin
					rd_j_s1 <= j_q;
					if (j_last) begin
						state_q <= ST_RB_DRAIN;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_RB_DRAIN: begin
					if (rb_empty) begin
						if (i_last) begin
							state_q <= ST_FINISH;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= ST_RB_START;
						end
					end
				end
				ST_WALK_POP: begin
					if (pending_q == '0) begin
						if (!best_mode_q) begin
							res_q.reached_count <= 7'(cnt_q);
							state_q <= ST_FINISH;
						end else begin
							best_cnt_q <= pick_cnt;
							best_idx_q <= pick_idx;
							if (i_last) begin
								res_q.reached_count <= 7'(pick_cnt);
								res_q.best_node     <= 6'(pick_idx);
								state_q <= ST_FINISH;
							end else begin
								i_q       <= i_q + IDX_W'(1);
								pending_q <= MAX_NODES'(1) << (i_q + IDX_W'(1));
								visited_q <= '0;
								cnt_q     <= '0;
							end
						end
					end else begin
						pending_q[pop_idx] <= 1'b0;
						if (!visited_q[pop_idx]) begin
							visited_q[pop_idx] <= 1'b1;
							cnt_q   <= cnt_q + CNT_W'(1);
							rv_s1   <= row_valid_q[pop_idx];
							state_q <= ST_WALK_MERGE;
						end
					end
				end
				ST_WALK_MERGE: begin
					pending_q <= pending_q
						| ((rv_s1 ? adj_rdata_q : '0) & active & ~visited_q);
					state_q <= ST_WALK_POP;
				end
				ST_FINISH: begin
					if (!rsp_valid || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The response payload changes only when a new item is loaded.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && (!rsp_valid || !rsp_stall)) begin
			rsp <= res_q;
		end
	end

	// Rebuild hits are collected into the row under construction, which is
	// cleared when the source disk is latched.
	always_ff @(posedge clk) begin
		if (state_q == ST_RB_LATCH) begin
			row_q <= '0;
		end else if (hit_valid && hit) begin
			row_q[hit_idx] <= 1'b1;
		end
	end

	`DCR_ASSERT_ALWAYS(a_pending_unvisited, (pending_q & visited_q) == '0,
		"pending disk already visited")
	`DCR_ASSERT_ALWAYS(a_count_matches, cnt_q == CNT_W'($countones(visited_q)),
		"reached count differs from visited set")
	`DCR_ASSERT_IMPLY(a_hit_in_rebuild, hit_valid,
		state_q == ST_RB_SCAN || state_q == ST_RB_DRAIN,
		"cover result outside a rebuild scan")

endmodule
